// ----- rtl/core/fsme_pkg.sv -----
package fsme_pkg;

    typedef enum logic [4:0] {
        OP_LIT       = 5'd0,
        OP_CALL      = 5'd1,
        OP_EXIT      = 5'd2,
        OP_ADD       = 5'd3,
        OP_SUB       = 5'd4,
        OP_AND       = 5'd5,
        OP_OR        = 5'd6,
        OP_XOR       = 5'd7,
        OP_DIV       = 5'd8,
        OP_MOD       = 5'd9,
        OP_MIN       = 5'd10,
        OP_MAX       = 5'd11,
        OP_ABS       = 5'd12,
        OP_INC       = 5'd13,
        OP_DEC       = 5'd14,
        OP_DEPTH     = 5'd15,
        OP_FETCH     = 5'd16,
        OP_STORE     = 5'd17,
        OP_BFETCH    = 5'd18,
        OP_BSTORE    = 5'd19
    } t_op;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_RET_OVF   = 3'd3;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd4;
    localparam logic [2:0] ST_ADDR      = 3'd5;

    localparam int IP_BITS = 17;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_DIV_FIX,
        S_MEM_RD,
        S_MEM_WR,
        S_WRITE,
        S_OUT
    } t_state;

endpackage

// ----- rtl/core/forth_stack_machine_execute.sv -----
// Forth execute stage. One instruction per transaction; the block drops
// s_axis_tready while it works and holds one result on the master side until
// taken. Plain words pass through accept, stack read, execute, write back and
// output register, and the output register waits while an earlier result is
// still stalled. Div and mod run a restoring divider one quotient bit a cycle.
// Cell fetch walks the byte memory byte by byte behind a registered read;
// cell store writes the cell byte by byte, and byte fetch and byte store move a
// single byte.
// Stack and memory contents come up undefined; reset does not clear them.
module forth_stack_machine_execute
    import fsme_pkg::*;
#(
    parameter int DATA_DEPTH   = 64,
    parameter int RETURN_DEPTH = 64,
    parameter int MEM_BYTES    = 65536,
    parameter int CELL_BITS    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] operation, [68:5] operand, [71:69] zero
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [63:0] top_value, [70:64] stack_depth, [87:71] next_ip, [90:88] status,
    // [95:91] zero
    output logic [95:0] m_axis_tdata
);

    localparam int DW = $clog2(DATA_DEPTH);
    localparam int RW = $clog2(RETURN_DEPTH);
    localparam int AW = $clog2(MEM_BYTES);
    localparam int CB = (CELL_BITS + 7) / 8;
    localparam int CBW = $clog2(CB + 1);
    localparam int CW = CELL_BITS;
    localparam int DCW = $clog2(DATA_DEPTH + 1);
    localparam int RCW = $clog2(RETURN_DEPTH + 1);
    localparam int KW = $clog2(CW + 1);
    localparam logic [63:0] CELL_MAX_ADDR = 64'(MEM_BYTES - CB);

    logic [CW-1:0] r_dstk [DATA_DEPTH];
    logic [IP_BITS-1:0] r_rstk [RETURN_DEPTH];
    logic [7:0] r_mem [MEM_BYTES];

    t_state r_state, n_state;
    logic [4:0] r_op;
    logic [63:0] r_operand;
    logic [DCW-1:0] r_dc;
    logic [RCW-1:0] r_rc;
    logic [IP_BITS-1:0] r_ip;
    logic [CW-1:0] r_a, r_b, r_top;
    logic [CW-1:0] r_res;
    logic [2:0] r_st;
    logic [CW-1:0] r_q, r_rem, r_un, r_ud;
    logic [KW-1:0] r_k;
    logic [CBW-1:0] r_bi;
    logic [AW-1:0] r_addr;
    logic [7:0] r_rd;
    logic r_wr_stk;
    logic [95:0] r_out;
    logic r_outv;

    logic running;
    logic [IP_BITS-1:0] nip_base;
    logic [15:0] ip_adv;
    logic [CW:0] trial;
    logic dc_ge1, dc_ge2, dc_full;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_outv;
    assign m_axis_tdata  = r_out;

    assign running  = ~r_ip[IP_BITS-1];
    assign ip_adv   = r_ip[15:0] + 16'(CB);
    assign nip_base = running ? {1'b0, ip_adv} : '1;
    assign dc_ge1   = r_dc >= DCW'(1);
    assign dc_ge2   = r_dc >= DCW'(2);
    assign dc_full  = r_dc >= DCW'(DATA_DEPTH);
    assign trial    = {r_rem[CW-2:0], r_un[CW-1]} - {1'b0, r_ud};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (s_axis_tvalid) n_state = S_READ;
            S_READ:    n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_WRITE;
                if (r_st == ST_OK) begin
                    if ((r_op == OP_DIV || r_op == OP_MOD) && dc_ge2 && r_a != '0)
                        n_state = S_DIV;
                    else if ((r_op == OP_FETCH || r_op == OP_BFETCH) && dc_ge1 &&
                             r_a <= (r_op == OP_FETCH ? CW'(CELL_MAX_ADDR)
                                                      : CW'(MEM_BYTES - 1)) &&
                             ~r_a[CW-1])
                        n_state = S_MEM_RD;
                    else if ((r_op == OP_STORE || r_op == OP_BSTORE) && dc_ge2 &&
                             r_a <= (r_op == OP_STORE ? CW'(CELL_MAX_ADDR)
                                                      : CW'(MEM_BYTES - 1)) &&
                             ~r_a[CW-1])
                        n_state = S_MEM_WR;
                end
            end
            S_DIV:     if (r_k == KW'(1)) n_state = S_DIV_FIX;
            S_DIV_FIX: n_state = S_WRITE;
            S_MEM_RD:  if (r_bi == CBW'(r_op == OP_FETCH ? CB : 1)) n_state = S_WRITE;
            S_MEM_WR:  if (r_bi == CBW'((r_op == OP_STORE ? CB : 1) - 1)) n_state = S_WRITE;
            S_WRITE:   n_state = S_OUT;
            S_OUT:     if (!r_outv || m_axis_tready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dc    <= '0;
            r_rc    <= '0;
            r_ip    <= '1;
            r_outv  <= 1'b0;
            r_wr_stk <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_outv && m_axis_tready) r_outv <= 1'b0;
            case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_op      <= s_axis_tdata[4:0];
                    r_operand <= s_axis_tdata[68:5];
                end
                S_READ: begin
                    r_a <= dc_ge1 ? r_dstk[DW'(r_dc - DCW'(1))] : '0;
                    r_b <= dc_ge2 ? r_dstk[DW'(r_dc - DCW'(2))] : '0;
                    r_st <= ST_OK;
                end
                S_EXEC: begin
                    r_wr_stk <= 1'b0;
                    r_un <= r_b[CW-1] ? CW'(-r_b) : r_b;
                    r_ud <= r_a[CW-1] ? CW'(-r_a) : r_a;
                    r_rem <= '0;
                    r_q <= '0;
                    r_k <= KW'(CW);
                    r_bi <= '0;
                    r_res <= '0;
                    r_addr <= r_a[AW-1:0];
                    case (r_op)
                        OP_LIT: if (dc_full) r_st <= ST_OVERFLOW;
                                else begin r_res <= r_operand[CW-1:0]; r_wr_stk <= 1'b1; end
                        OP_CALL: if (r_operand >= 64'd65536) r_st <= ST_ADDR;
                                 else if (running && r_rc >= RCW'(RETURN_DEPTH))
                                     r_st <= ST_RET_OVF;
                        OP_EXIT: ;
                        OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_DIV, OP_MOD,
                        OP_MIN, OP_MAX: begin
                            if (!dc_ge2) r_st <= ST_UNDERFLOW;
                            else if ((r_op == OP_DIV || r_op == OP_MOD) && r_a == '0)
                                r_st <= ST_DIV_ZERO;
                            else begin
                                r_wr_stk <= 1'b1;
                                case (r_op)
                                    OP_ADD: r_res <= r_b + r_a;
                                    OP_SUB: r_res <= r_b - r_a;
                                    OP_AND: r_res <= r_b & r_a;
                                    OP_OR:  r_res <= r_b | r_a;
                                    OP_XOR: r_res <= r_b ^ r_a;
                                    OP_MIN: r_res <= ($signed(r_a) < $signed(r_b)) ? r_a : r_b;
                                    OP_MAX: r_res <= ($signed(r_b) < $signed(r_a)) ? r_a : r_b;
                                    default: ;
                                endcase
                            end
                        end
                        OP_ABS, OP_INC, OP_DEC: if (!dc_ge1) r_st <= ST_UNDERFLOW;
                            else begin
                                r_wr_stk <= 1'b1;
                                if (r_op == OP_ABS) r_res <= r_a[CW-1] ? CW'(-r_a) : r_a;
                                else if (r_op == OP_INC) r_res <= r_a + CW'(1);
                                else r_res <= r_a - CW'(1);
                            end
                        OP_DEPTH: if (dc_full) r_st <= ST_OVERFLOW;
                                  else begin r_res <= CW'(r_dc); r_wr_stk <= 1'b1; end
                        OP_FETCH, OP_BFETCH: if (!dc_ge1) r_st <= ST_UNDERFLOW;
                            else if (r_a[CW-1] || r_a > (r_op == OP_FETCH ?
                                     CW'(CELL_MAX_ADDR) : CW'(MEM_BYTES - 1)))
                                r_st <= ST_ADDR;
                            else r_wr_stk <= 1'b1;
                        OP_STORE, OP_BSTORE: if (!dc_ge2) r_st <= ST_UNDERFLOW;
                            else if (r_a[CW-1] || r_a > (r_op == OP_STORE ?
                                     CW'(CELL_MAX_ADDR) : CW'(MEM_BYTES - 1)))
                                r_st <= ST_ADDR;
                        default: ;
                    endcase
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    r_un <= {r_un[CW-2:0], 1'b0};
                    if (!trial[CW]) begin
                        r_rem <= trial[CW-1:0];
                        r_q   <= {r_q[CW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[CW-2:0], r_un[CW-1]};
                        r_q   <= {r_q[CW-2:0], 1'b0};
                    end
                    r_k <= r_k - KW'(1);
                end
                S_DIV_FIX: begin
                    if (r_op == OP_MOD) r_res <= r_b[CW-1] ? CW'(-r_rem) : r_rem;
                    else r_res <= (r_b[CW-1] ^ r_a[CW-1]) ? CW'(-r_q) : r_q;
                end
                S_MEM_RD: begin
                    r_rd <= r_mem[r_addr + AW'(r_bi)];
                    if (r_bi != '0) begin
                        if (r_op == OP_FETCH)
                            r_res <= r_res | (CW'(r_rd) << (8 * (32'(r_bi) - 1)));
                        else
                            r_res <= CW'($signed(r_rd));
                    end
                    r_bi <= r_bi + CBW'(1);
                end
                S_MEM_WR: r_bi <= r_bi + CBW'(1);
                S_WRITE: if (r_st == ST_OK) begin
                    r_ip <= nip_base;
                    case (r_op)
                        OP_LIT: begin
                            r_dc <= r_dc + DCW'(1);
                            r_top <= r_res;
                            if (running) r_ip <= {1'b0, nip_base[15:0] + 16'(CB)};
                        end
                        OP_DEPTH: begin r_dc <= r_dc + DCW'(1); r_top <= r_res; end
                        OP_CALL: begin
                            if (running) r_rc <= r_rc + RCW'(1);
                            r_ip <= r_operand[IP_BITS-1:0];
                        end
                        OP_EXIT: if (r_rc != '0) begin
                            r_rc <= r_rc - RCW'(1);
                            r_ip <= {1'b0, r_rstk[RW'(r_rc - RCW'(1))][15:0]};
                        end else r_ip <= '1;
                        OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_DIV, OP_MOD,
                        OP_MIN, OP_MAX: begin r_dc <= r_dc - DCW'(1); r_top <= r_res; end
                        OP_ABS, OP_INC, OP_DEC, OP_FETCH, OP_BFETCH: r_top <= r_res;
                        OP_STORE, OP_BSTORE: begin
                            r_dc <= r_dc - DCW'(2);
                            r_top <= (r_dc >= DCW'(3)) ? r_dstk[DW'(r_dc - DCW'(3))] : '0;
                        end
                        default: ;
                    endcase
                end
                S_OUT: if (!r_outv || m_axis_tready) begin
                    r_outv <= 1'b1;
                    r_out  <= {5'd0, r_st, r_ip, 7'(r_dc),
                               (r_dc == '0) ? 64'd0 : 64'($signed(r_top))};
                end
                default: ;
            endcase
        end
    end

    // Stacks and memory: one write port each.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && r_st == ST_OK) begin
            if (r_wr_stk) begin
                if (r_op == OP_LIT || r_op == OP_DEPTH)
                    r_dstk[DW'(r_dc)] <= r_res;
                else if (r_op == OP_ABS || r_op == OP_INC || r_op == OP_DEC ||
                         r_op == OP_FETCH || r_op == OP_BFETCH)
                    r_dstk[DW'(r_dc - DCW'(1))] <= r_res;
                else
                    r_dstk[DW'(r_dc - DCW'(2))] <= r_res;
            end
            if (r_op == OP_CALL && running)
                r_rstk[RW'(r_rc)] <= nip_base;
        end
        if (r_state == S_MEM_WR)
            r_mem[r_addr + AW'(r_bi)] <= 8'(r_b >> (8 * 32'(r_bi)));
    end

endmodule

// ----- rtl/core/fsme_checker.sv -----
module fsme_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[90:88] <= 3'd5)
        else $error("bad status code");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted two transactions back to back");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[70:64] <= 7'd64)
        else $error("stack depth out of range");

endmodule

bind forth_stack_machine_execute fsme_checker u_fsme_checker (.*);

// ----- dv/forth_stack_machine_execute_tb.sv -----
module forth_stack_machine_execute_tb;
    import fsme_pkg::*;

    localparam int DEPTH     = 64;
    localparam int RDEPTH    = 64;
    localparam int MEM_SIZE  = 65536;
    localparam int CELL_SZ   = 8;

    typedef struct packed {
        logic [2:0]  status;
        logic [16:0] next_ip;
        logic [6:0]  depth;
        logic [63:0] top;
    } t_result;

    // Behavioral copy of the execute stage plus a queue of pending results.
    class exec_scoreboard;
        logic [63:0] dstk [DEPTH];
        int          dcnt;
        logic [16:0] rstk [RDEPTH];
        int          rcnt;
        int          ip;
        logic [7:0]  mem [int];
        t_result     pending [$];
        int          errors;

        function new();
            dcnt   = 0;
            rcnt   = 0;
            ip     = -1;
            errors = 0;
        endfunction

        function logic [7:0] rd_byte(longint unsigned addr);
            logic [7:0] v;
            v = 8'h00;
            if (mem.exists(int'(addr))) v = mem[int'(addr)];
            return v;
        endfunction

        function void note_instr(t_op op, logic [63:0] opnd);
            logic [2:0]  st;
            logic [63:0] a, b, r, ua, ub, q, rm;
            logic [7:0]  bv;
            int          nip;
            bit          run;
            t_result     res;
            st  = ST_OK;
            run = (ip >= 0);
            nip = run ? ((ip + CELL_SZ) & 16'hFFFF) : -1;
            a   = (dcnt >= 1) ? dstk[dcnt-1] : 64'd0;
            b   = (dcnt >= 2) ? dstk[dcnt-2] : 64'd0;
            r   = 64'd0;
            case (op)
                OP_LIT: begin
                    if (dcnt >= DEPTH) st = ST_OVERFLOW;
                    else begin
                        dstk[dcnt] = opnd;
                        dcnt++;
                        if (run) nip = (nip + CELL_SZ) & 16'hFFFF;
                    end
                end
                OP_CALL: begin
                    if (opnd >= 64'd65536) st = ST_ADDR;
                    else if (run && rcnt >= RDEPTH) st = ST_RET_OVF;
                    else begin
                        if (run) begin
                            rstk[rcnt] = nip[16:0];
                            rcnt++;
                        end
                        nip = int'(opnd[16:0]);
                    end
                end
                OP_EXIT: begin
                    if (rcnt > 0) begin
                        rcnt--;
                        nip = int'(rstk[rcnt][15:0]);
                    end else nip = -1;
                end
                OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_DIV, OP_MOD, OP_MIN,
                OP_MAX: begin
                    if (dcnt < 2) st = ST_UNDERFLOW;
                    else begin
                        case (op)
                            OP_ADD: r = b + a;
                            OP_SUB: r = b - a;
                            OP_AND: r = b & a;
                            OP_OR:  r = b | a;
                            OP_XOR: r = b ^ a;
                            OP_MIN: r = ($signed(a) < $signed(b)) ? a : b;
                            OP_MAX: r = ($signed(b) < $signed(a)) ? a : b;
                            default: begin
                                if (a == 0) st = ST_DIV_ZERO;
                                else begin
                                    ub = b[63] ? -b : b;
                                    ua = a[63] ? -a : a;
                                    q  = ub / ua;
                                    rm = ub % ua;
                                    if (a[63] != b[63]) q = -q;
                                    if (b[63]) rm = -rm;
                                    r = (op == OP_MOD) ? rm : q;
                                end
                            end
                        endcase
                        if (st == ST_OK) begin
                            dstk[dcnt-2] = r;
                            dcnt--;
                        end
                    end
                end
                OP_ABS, OP_INC, OP_DEC: begin
                    if (dcnt < 1) st = ST_UNDERFLOW;
                    else if (op == OP_ABS) dstk[dcnt-1] = a[63] ? -a : a;
                    else if (op == OP_INC) dstk[dcnt-1] = a + 1;
                    else dstk[dcnt-1] = a - 1;
                end
                OP_DEPTH: begin
                    if (dcnt >= DEPTH) st = ST_OVERFLOW;
                    else begin
                        dstk[dcnt] = 64'(dcnt);
                        dcnt++;
                    end
                end
                OP_FETCH: begin
                    if (dcnt < 1) st = ST_UNDERFLOW;
                    else if (a > 64'(MEM_SIZE - CELL_SZ)) st = ST_ADDR;
                    else begin
                        for (int i = 0; i < CELL_SZ; i++) r[8*i +: 8] = rd_byte(a + i);
                        dstk[dcnt-1] = r;
                    end
                end
                OP_STORE: begin
                    if (dcnt < 2) st = ST_UNDERFLOW;
                    else if (a > 64'(MEM_SIZE - CELL_SZ)) st = ST_ADDR;
                    else begin
                        for (int i = 0; i < CELL_SZ; i++) mem[int'(a) + i] = b[8*i +: 8];
                        dcnt -= 2;
                    end
                end
                OP_BFETCH: begin
                    if (dcnt < 1) st = ST_UNDERFLOW;
                    else if (a >= 64'(MEM_SIZE)) st = ST_ADDR;
                    else begin
                        bv = rd_byte(a);
                        dstk[dcnt-1] = {{56{bv[7]}}, bv};
                    end
                end
                OP_BSTORE: begin
                    if (dcnt < 2) st = ST_UNDERFLOW;
                    else if (a >= 64'(MEM_SIZE)) st = ST_ADDR;
                    else begin
                        mem[int'(a)] = b[7:0];
                        dcnt -= 2;
                    end
                end
                default: ;
            endcase
            if (st == ST_OK) ip = nip;
            res.top     = (dcnt > 0) ? dstk[dcnt-1] : 64'd0;
            res.depth   = 7'(dcnt);
            res.next_ip = (ip < 0) ? 17'h1FFFF : 17'(ip);
            res.status  = st;
            pending.push_back(res);
        endfunction

        function void check_result(logic [95:0] data);
            t_result got, exp;
            got = data[90:0];
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, data);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.top !== exp.top) begin
                $display("%0t: top_value exp %h got %h", $time, exp.top, got.top);
                errors++;
            end
            if (got.depth !== exp.depth) begin
                $display("%0t: stack_depth exp %0d got %0d", $time, exp.depth, got.depth);
                errors++;
            end
            if (got.next_ip !== exp.next_ip) begin
                $display("%0t: next_ip exp %h got %h", $time, exp.next_ip, got.next_ip);
                errors++;
            end
            if (got.status !== exp.status) begin
                $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
                errors++;
            end
            if (data[95:91] !== 5'd0) begin
                $display("%0t: pad exp 0 got %h", $time, data[95:91]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // [4:0] operation, [68:5] operand, [71:69] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [63:0] top_value, [70:64] stack_depth, [87:71] next_ip, [90:88] status
    logic [95:0] m_axis_tdata;

    exec_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;

    forth_stack_machine_execute dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #40000000;
        $display("status: fail");
        $finish;
    end

    // Valid stays high from one transaction into the next unless the sender
    // idles, so valid gets at most one update per clock edge.
    task automatic send_instr(t_op op, logic [63:0] opnd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, opnd, 5'(op)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_instr(op, opnd);
    endtask

    // Picks a random operand value: the most negative or most positive signed
    // cell, all ones, a small number up to 20 or a random 64-bit word.
    function automatic logic [63:0] pick_value();
        case ($urandom_range(5))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'(-1);
            3: return 64'($urandom_range(20));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random instruction with operands chosen so memory reads stay on written
    // cells; the stack contents of the scoreboard guide the choice.
    task automatic random_instr();
        int          k;
        t_op         op;
        logic [63:0] opnd, a;
        bit          ok;
        k    = $urandom_range(99);
        opnd = pick_value();
        a    = (sb.dcnt >= 1) ? sb.dstk[sb.dcnt-1] : 64'd0;
        if (k < 25) op = OP_LIT;
        else if (k < 30) begin
            op = OP_CALL;
            opnd = ($urandom_range(9) == 0) ? pick_value() : 64'($urandom_range(65535));
        end
        else if (k < 35) op = OP_EXIT;
        else if (k < 70) op = t_op'($urandom_range(OP_DEPTH, OP_ADD));
        else if (k < 74) begin
            // Address literal: anywhere in range, in the low 256 bytes, near the top or random.
            op = OP_LIT;
            case ($urandom_range(3))
                0: opnd = 64'($urandom_range(MEM_SIZE - CELL_SZ));
                1: opnd = 64'($urandom_range(255));
                2: opnd = 64'(MEM_SIZE - CELL_SZ + $urandom_range(16));
                default: opnd = {$urandom, $urandom};
            endcase
        end
        else if (k < 84) op = ($urandom_range(1)) ? OP_STORE : OP_BSTORE;
        else if (k < 97) begin
            op = ($urandom_range(1)) ? OP_FETCH : OP_BFETCH;
            ok = 1;
            if (sb.dcnt >= 1) begin
                if (op == OP_FETCH && a <= 64'(MEM_SIZE - CELL_SZ)) begin
                    for (int i = 0; i < CELL_SZ; i++)
                        if (!sb.mem.exists(int'(a) + i)) ok = 0;
                end else if (op == OP_BFETCH && a < 64'(MEM_SIZE)) begin
                    if (!sb.mem.exists(int'(a))) ok = 0;
                end
            end
            if (!ok) op = OP_DEPTH;
        end
        else op = t_op'($urandom_range(31, 20));
        send_instr(op, opnd);
    endtask

    initial begin
        sb = new();
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: errors on empty stacks, halted call and exit, wrap cases.
        send_instr(OP_ADD, 64'd0);
        send_instr(OP_ABS, 64'd0);
        send_instr(OP_STORE, 64'd0);
        send_instr(OP_EXIT, 64'd0);
        send_instr(OP_LIT, 64'd5);
        send_instr(OP_CALL, 64'd65536);
        send_instr(OP_CALL, 64'd65535);
        send_instr(OP_CALL, 64'd100);
        send_instr(OP_LIT, 64'h8000_0000_0000_0000);
        send_instr(OP_LIT, 64'(-1));
        send_instr(OP_DIV, 64'd0);
        send_instr(OP_LIT, 64'h8000_0000_0000_0000);
        send_instr(OP_LIT, 64'(-1));
        send_instr(OP_MOD, 64'd0);
        send_instr(OP_ABS, 64'd0);
        send_instr(OP_LIT, 64'd0);
        send_instr(OP_DIV, 64'd0);
        send_instr(OP_LIT, 64'h7FFF_FFFF_FFFF_FFFF);
        send_instr(OP_INC, 64'd0);
        send_instr(OP_LIT, 64'd65528);
        send_instr(OP_STORE, 64'd0);
        send_instr(OP_LIT, 64'd65529);
        send_instr(OP_FETCH, 64'd0);
        send_instr(OP_LIT, 64'd65528);
        send_instr(OP_FETCH, 64'd0);
        send_instr(OP_EXIT, 64'd0);
        send_instr(OP_EXIT, 64'd0);

        // Fill both stacks to their limits for overflow coverage.
        for (int i = 0; i < 66; i++) send_instr(OP_DEPTH, 64'd0);
        send_instr(OP_CALL, 64'd0);
        for (int i = 0; i < 66; i++) send_instr(OP_CALL, 64'($urandom_range(65535)));
        for (int i = 0; i < 70; i++) send_instr(OP_EXIT, 64'd0);
        for (int i = 0; i < 66; i++) send_instr(OP_XOR, 64'd0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int n = 0; n < 330; n++) random_instr();
        end
        s_axis_tvalid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/fsme_pkg.sv
rtl/core/forth_stack_machine_execute.sv
rtl/core/fsme_checker.sv
dv/forth_stack_machine_execute_tb.sv
